// ===== rtl/core/osta_pkg.sv =====
// ----------------------------------------------------------------------------
// osta_pkg: shared constants and helpers for the spectrum time advance block
// Holds the fixed-point constants, the arctangent table and the channel types.
// ----------------------------------------------------------------------------
package osta_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 30;

    // 2*pi in Q32.32, pi, pi/2 and 2*pi in Q2.30
    localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
    localparam logic signed [33:0] TRIG_MAX    = 34'sd1073741823;

    typedef logic signed [31:0] t_q16;

    function automatic logic signed [33:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic t_q16 sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -68'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Payload carried beside the phase pipeline.
    typedef struct packed {
        logic [32:0] a_re;
        logic [32:0] a_im;
        logic [32:0] d_re;
        logic [32:0] d_im;
        t_q16 wave_x;
        t_q16 wave_z;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_z;
    } t_side;

endpackage

// ===== rtl/core/osta_phase.sv =====
// ----------------------------------------------------------------------------
// osta_phase: phase product and modulo 2*pi reduction
// Multiplies rate by time in 16-bit partial products and reduces the product
// by conditional subtraction of multiples of 2*pi, one bit a stage.
// ----------------------------------------------------------------------------
module osta_phase (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [30:0] i_rate,
    input  logic [30:0] i_time,
    output logic        o_valid,
    output logic signed [33:0] o_angle
);
    // Product is below 2^62; quotient by 2*pi*2^32 is below 2^28.
    localparam int RED_BITS = 28;
    localparam logic [34:0] TWO_PI_W = osta_pkg::TWO_PI_Q32;

    logic [30:0] r_ra, r_ta;
    logic [46:0] r_lo, r_hi;
    logic        r_v0, r_v1;
    logic [61:0] r_p [RED_BITS+1];
    logic        r_pv [RED_BITS+1];
    logic signed [33:0] r_ang;
    logic        r_av;
    logic signed [33:0] n_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_av <= 1'b0;
            for (int k = 0; k <= RED_BITS; k++) r_pv[k] <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_pv[0] <= r_v1;
            for (int k = 1; k <= RED_BITS; k++) r_pv[k] <= r_pv[k-1];
            r_av <= r_pv[RED_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ra <= i_rate;
            r_ta <= i_time;
            r_lo <= 47'(r_ra * r_ta[15:0]);
            r_hi <= 47'(r_ra * r_ta[30:16]);
            r_p[0] <= 62'({15'd0, r_lo}) + 62'({r_hi, 16'd0});
            for (int k = 1; k <= RED_BITS; k++) begin
                if (r_p[k-1] >= (62'(TWO_PI_W) << (RED_BITS - k)))
                    r_p[k] <= r_p[k-1] - (62'(TWO_PI_W) << (RED_BITS - k));
                else
                    r_p[k] <= r_p[k-1];
            end
            r_ang <= n_ang;
        end
    end

    always_comb begin
        n_ang = $signed({1'b0, r_p[RED_BITS][34:2]});
        if (n_ang >= osta_pkg::PI_Q30) n_ang = n_ang - osta_pkg::TWO_PI_Q30;
    end

    assign o_valid = r_av;
    assign o_angle = r_ang;
endmodule

// ===== rtl/core/osta_cordic.sv =====
// ----------------------------------------------------------------------------
// osta_cordic: pipelined rotation-mode CORDIC with quadrant fold
// One micro-rotation per register stage; output clamped to +-(2^30 - 1).
// ----------------------------------------------------------------------------
module osta_cordic #(
    parameter int STAGES = osta_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic signed [33:0] i_angle,
    output logic        o_valid,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    logic signed [33:0] r_x [STAGES+1];
    logic signed [33:0] r_y [STAGES+1];
    logic signed [33:0] r_z [STAGES+1];
    logic               r_n [STAGES+1];
    logic               r_v [STAGES+1];
    logic signed [33:0] r_c, r_s, n_c, n_s;
    logic               r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= STAGES; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= osta_pkg::GAIN_INV;
            r_y[0] <= '0;
            if (i_angle > osta_pkg::HALF_PI_Q30) begin
                r_z[0] <= i_angle - osta_pkg::PI_Q30;
                r_n[0] <= 1'b1;
            end else if (i_angle < -osta_pkg::HALF_PI_Q30) begin
                r_z[0] <= i_angle + osta_pkg::PI_Q30;
                r_n[0] <= 1'b1;
            end else begin
                r_z[0] <= i_angle;
                r_n[0] <= 1'b0;
            end
            for (int k = 0; k < STAGES; k++) begin
                r_n[k+1] <= r_n[k];
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - osta_pkg::atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + osta_pkg::atan_q30(k);
                end
            end
            r_c <= n_c;
            r_s <= n_s;
        end
    end

    always_comb begin
        n_c = r_n[STAGES] ? -r_x[STAGES] : r_x[STAGES];
        n_s = r_n[STAGES] ? -r_y[STAGES] : r_y[STAGES];
        if (n_c > osta_pkg::TRIG_MAX) n_c = osta_pkg::TRIG_MAX;
        if (n_c < -osta_pkg::TRIG_MAX) n_c = -osta_pkg::TRIG_MAX;
        if (n_s > osta_pkg::TRIG_MAX) n_s = osta_pkg::TRIG_MAX;
        if (n_s < -osta_pkg::TRIG_MAX) n_s = -osta_pkg::TRIG_MAX;
    end

    assign o_valid = r_ov;
    assign o_cos   = r_c;
    assign o_sin   = r_s;
endmodule

// ===== rtl/core/osta_mix.sv =====
// ----------------------------------------------------------------------------
// osta_mix: height spectrum and the four i*k products
// Stage 1 multiplies, stage 2 sums and rounds, stage 3 scales by each factor,
// stage 4 rounds and saturates.
// ----------------------------------------------------------------------------
module osta_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic signed [33:0] i_cos,
    input  logic signed [33:0] i_sin,
    input  osta_pkg::t_side i_side,
    output logic        o_valid,
    output logic [319:0] o_res
);
    logic signed [67:0] r_m0, r_m1, r_m2, r_m3;
    osta_pkg::t_side    r_s1, r_s2;
    osta_pkg::t_q16     r_hr, r_hi;
    logic signed [67:0] r_p [8];
    osta_pkg::t_q16     r_h2r, r_h2i;
    logic [319:0]       r_res;
    logic [3:0]         r_v;
    logic signed [67:0] w_hr, w_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (i_en) r_v <= {r_v[2:0], i_valid};
    end

    assign w_hr = r_m0 - r_m1 + (68'sd1 <<< 29);
    assign w_hi = r_m2 + r_m3 + (68'sd1 <<< 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m0 <= $signed(i_side.a_re) * i_cos;
            r_m1 <= $signed(i_side.a_im) * i_sin;
            r_m2 <= $signed(i_side.d_re) * i_sin;
            r_m3 <= $signed(i_side.d_im) * i_cos;
            r_s1 <= i_side;
            r_hr <= osta_pkg::sat32(w_hr >>> 30);
            r_hi <= osta_pkg::sat32(w_hi >>> 30);
            r_s2 <= r_s1;
            r_p[0] <= -(68'(r_s2.wave_x) * r_hi);
            r_p[1] <= 68'(r_s2.wave_x) * r_hr;
            r_p[2] <= -(68'(r_s2.wave_z) * r_hi);
            r_p[3] <= 68'(r_s2.wave_z) * r_hr;
            r_p[4] <= -(68'(r_s2.dir_x) * r_hi);
            r_p[5] <= 68'(r_s2.dir_x) * r_hr;
            r_p[6] <= -(68'(r_s2.dir_z) * r_hi);
            r_p[7] <= 68'(r_s2.dir_z) * r_hr;
            r_h2r <= r_hr;
            r_h2i <= r_hi;
            r_res[31:0]  <= r_h2r;
            r_res[63:32] <= r_h2i;
            for (int k = 0; k < 8; k++)
                r_res[64+32*k +: 32] <= osta_pkg::sat32((r_p[k] + 68'sd32768) >>> 16);
        end
    end

    assign o_valid = r_v[3];
    assign o_res   = r_res;
endmodule

// ===== rtl/core/ocean_spectrum_time_advance_unit.sv =====
// ----------------------------------------------------------------------------
// ocean_spectrum_time_advance_unit: moves one spectrum cell to current time
// Top level: input delay line, phase reduction, CORDIC and output mixing.
// ----------------------------------------------------------------------------
// Use: write elapsed_time through i_cfg_we/i_cfg_wdata once per frame while
// idle. Each request on s_axis carries one spectrum cell (amplitude, mirrored
// amplitude, wave vector, choppiness and dispersion); each request on m_axis
// carries height, two slopes and two displacements, ten Q16.16 words.
// The unit takes one cell per clock while the output is not stalled. Each
// result is registered after the phase product, the modulo 2*pi reduction,
// the wrap, the fold, the one-rotation-per-stage CORDIC and the clamp, and
// the output mixing. The whole pipeline advances together under one enable;
// it moves whenever the output register is empty or being taken, so a
// stalled receiver freezes every stage and nothing is lost or repeated.
// s_axis_tready follows that same enable.
// Reset (i_rst_n low at a clock edge) clears every valid bit and sets
// elapsed_time to zero; payload registers are not reset.
// ----------------------------------------------------------------------------
module ocean_spectrum_time_advance_unit #(
    parameter int CORDIC_STAGES = osta_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // amp_re, amp_im, mirror_re, mirror_im, wave_x, wave_z, dir_x, dir_z,
    // angular_rate, from bit 0 up; zero filled to 264 bits
    input  logic [263:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // height_re, height_im, slope_x_re, slope_x_im, slope_z_re, slope_z_im,
    // shift_x_re, shift_x_im, shift_z_re, shift_z_im, from bit 0 up
    output logic [319:0] m_axis_tdata
);
    localparam int SIDE_DLY = 34 + CORDIC_STAGES;

    logic [30:0] r_time;
    logic        w_en;
    logic        w_pv, w_cv;
    logic signed [33:0] w_ang, w_cos, w_sin;
    osta_pkg::t_side n_side;
    osta_pkg::t_side r_side [SIDE_DLY];

    // The pipeline moves when its last stage is empty or is being taken.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_time <= '0;
        else if (i_cfg_we) r_time <= i_cfg_wdata;
    end

    always_comb begin
        n_side.a_re   = 33'($signed(s_axis_tdata[31:0]))  + 33'($signed(s_axis_tdata[95:64]));
        n_side.a_im   = 33'($signed(s_axis_tdata[63:32])) + 33'($signed(s_axis_tdata[127:96]));
        n_side.d_re   = 33'($signed(s_axis_tdata[31:0]))  - 33'($signed(s_axis_tdata[95:64]));
        n_side.d_im   = 33'($signed(s_axis_tdata[63:32])) - 33'($signed(s_axis_tdata[127:96]));
        n_side.wave_x = s_axis_tdata[159:128];
        n_side.wave_z = s_axis_tdata[191:160];
        n_side.dir_x  = s_axis_tdata[209:192];
        n_side.dir_z  = s_axis_tdata[227:210];
    end

    // Operands wait beside the phase and CORDIC stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_DLY; k++) r_side[k] <= r_side[k-1];
        end
    end

    osta_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_rate  (s_axis_tdata[258:228]),
        .i_time  (r_time),
        .o_valid (w_pv),
        .o_angle (w_ang)
    );

    osta_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_pv),
        .i_angle (w_ang),
        .o_valid (w_cv),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    osta_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_side  (r_side[SIDE_DLY-1]),
        .o_valid (m_axis_tvalid),
        .o_res   (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    // A stalled result must stay put until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // Input is accepted exactly when the pipeline advances.
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not track pipeline enable");
    // Cosine is clamped inside the Q2.30 unit range.
    a_cos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv |-> (w_cos <= osta_pkg::TRIG_MAX) && (w_cos >= -osta_pkg::TRIG_MAX))
        else $error("cosine out of range");
`endif
endmodule
